@@ rtl/srcu_pkg.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller package
// Shared types, codes and constants for the registration controller.
// ----------------------------------------------------------------------------
`default_nettype none

package srcu_pkg;

   // Registration phases, as reported on the result channel.
   typedef enum logic [2:0] {
      PH_UNREG         = 3'd0,
      PH_REGISTER      = 3'd1,
      PH_REGISTERING   = 3'd2,
      PH_REGISTERED    = 3'd3,
      PH_UNREGISTER    = 3'd4,
      PH_UNREGISTERING = 3'd5
   } phase_type;

   // Request kinds.
   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_RESPONSE   = 2'd1,
      ACT_REGISTER   = 2'd2,
      ACT_UNREGISTER = 2'd3
   } action_type;

   // Error kinds.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TIMEOUT   = 2'd1,
      ERR_FORBIDDEN = 2'd2,
      ERR_REGISTER  = 2'd3
   } err_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TRY_LIMIT        = 2'd0,
      CSR_RESPONSE_TIMEOUT = 2'd1,
      CSR_DEFAULT_EXPIRY   = 2'd2,
      CSR_FIXED_EXPIRY     = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // SIP status codes of interest.
   localparam logic [9:0] CODE_TRYING     = 10'd100;
   localparam logic [9:0] CODE_OK         = 10'd200;
   localparam logic [9:0] CODE_UNAUTH     = 10'd401;
   localparam logic [9:0] CODE_PROXY_AUTH = 10'd407;
   localparam logic [9:0] CODE_FORBIDDEN  = 10'd403;
   localparam logic [9:0] CODE_ERR_LOW    = 10'd400;
   localparam logic [9:0] CODE_ERR_HIGH   = 10'd600;

   localparam logic [9:0]  MS_PER_S   = 10'd1000;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   // Configuration reset values.
   localparam logic [3:0]  TRY_LIMIT_RST        = 4'd3;
   localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd4000;
   localparam logic [15:0] DEFAULT_EXPIRY_RST   = 16'd3600;
   localparam logic [15:0] FIXED_EXPIRY_RST     = 16'd0;

   typedef struct packed {
      action_type  action;
      logic        call_id_match;
      logic [9:0]  response_code;
      logic [15:0] response_expiry_s;
   } req_item_type;

   typedef struct packed {
      logic        send_register;
      logic        send_unregister;
      logic        load_auth;
      logic        clear_auth;
      err_type     error_kind;
      logic [9:0]  error_sip_code;
      logic        registered_event;
      logic        unregistered_event;
      phase_type   phase;
      logic        is_registered;
      logic [15:0] error_count;
      logic [15:0] success_count;
   } rsp_item_type;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic [3:0]  try_limit;
      logic [15:0] response_timeout_ms;
      logic [15:0] default_expiry_s;
      logic [15:0] fixed_expiry_s;
      logic        fixed_load;
   } csr_cfg_type;

endpackage

`default_nettype wire

@@ rtl/srcu_if.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller channel interfaces
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface srcu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        call_id_match;
   logic [9:0]  response_code;
   logic [15:0] response_expiry_s;

   modport source (
      output valid, action, call_id_match, response_code, response_expiry_s,
      input  ready
   );
   modport sink (
      input  valid, action, call_id_match, response_code, response_expiry_s,
      output ready
   );
endinterface

interface srcu_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_register;
   logic        send_unregister;
   logic        load_auth;
   logic        clear_auth;
   logic [1:0]  error_kind;
   logic [9:0]  error_sip_code;
   logic        registered_event;
   logic        unregistered_event;
   logic [2:0]  phase;
   logic        is_registered;
   logic [15:0] error_count;
   logic [15:0] success_count;

   modport source (
      output valid, send_register, send_unregister, load_auth, clear_auth,
             error_kind, error_sip_code, registered_event, unregistered_event,
             phase, is_registered, error_count, success_count,
      input  ready
   );
   modport sink (
      input  valid, send_register, send_unregister, load_auth, clear_auth,
             error_kind, error_sip_code, registered_event, unregistered_event,
             phase, is_registered, error_count, success_count,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/sip_registration_controller_unit.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller unit
// Client-side registration control: phases, retries, timers and counters.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle (a millisecond tick, a parsed
// server response, a register request or an unregister request) while its
// results are taken, and returns exactly one result for each. A request is
// captured in an input register, the registration state is updated by a
// single pass of logic once the output register can take the result, and the
// result lands in that output register. The sustained rate of one request per
// cycle, when the result channel does not stall, is set by that single-pass
// update; the output register lets a new request enter while a finished result
// still waits to be taken. Configuration is to be written through the CSR port
// only while the unit is idle; the unit does not enforce this. Writing the fixed
// expiry register also loads the held expiry time.
`default_nettype none

module sip_registration_controller_unit
   import srcu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   srcu_req_if.sink                    req_if,
   srcu_rsp_if.source                  rsp_if,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_cfg_type  cfg;
   rsp_item_type result;

   req_item_type req_item_ff;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         advance;
   logic         step;
   logic         req_accept;

   // The output stage can take a new result when it is empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_if.ready;
   // A request held in the input register is processed whenever the output
   // stage can take its result.
   assign step       = req_valid_ff && advance;
   assign req_if.ready = !req_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   assign req_valid_in = req_accept || (req_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_item_ff.action            <= action_type'(req_if.action);
         req_item_ff.call_id_match     <= req_if.call_id_match;
         req_item_ff.response_code     <= req_if.response_code;
         req_item_ff.response_expiry_s <= req_if.response_expiry_s;
      end
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   srcu_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   srcu_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.send_register      = rsp_item_ff.send_register;
   assign rsp_if.send_unregister    = rsp_item_ff.send_unregister;
   assign rsp_if.load_auth          = rsp_item_ff.load_auth;
   assign rsp_if.clear_auth         = rsp_item_ff.clear_auth;
   assign rsp_if.error_kind         = rsp_item_ff.error_kind;
   assign rsp_if.error_sip_code     = rsp_item_ff.error_sip_code;
   assign rsp_if.registered_event   = rsp_item_ff.registered_event;
   assign rsp_if.unregistered_event = rsp_item_ff.unregistered_event;
   assign rsp_if.phase              = rsp_item_ff.phase;
   assign rsp_if.is_registered      = rsp_item_ff.is_registered;
   assign rsp_if.error_count        = rsp_item_ff.error_count;
   assign rsp_if.success_count      = rsp_item_ff.success_count;

   // A processed request always leaves a result in the output register.
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed request did not produce a result");

   // Being in the registered phase implies the registered flag is set.
   a_registered_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.phase == PH_REGISTERED)
         |-> rsp_item_ff.is_registered)
      else $error("registered phase without registered flag");

   // Any reported error closes the registration.
   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.error_kind != ERR_NONE)
         |-> (rsp_item_ff.phase == PH_UNREG && !rsp_item_ff.is_registered))
      else $error("error reported without closing the registration");

   // A registered event always leaves the unit in the registered phase.
   a_event_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.registered_event)
         |-> rsp_item_ff.phase == PH_REGISTERED)
      else $error("registered event outside the registered phase");

endmodule

`default_nettype wire

@@ rtl/srcu_csr.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller configuration registers
// Holds the four configuration registers written through the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module srcu_csr
   import srcu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output csr_cfg_type                 cfg
);

   logic [3:0]  try_limit_ff,  try_limit_in;
   logic [15:0] timeout_ff,    timeout_in;
   logic [15:0] def_expiry_ff, def_expiry_in;
   logic [15:0] fix_expiry_ff, fix_expiry_in;
   logic        fix_load_ff,   fix_load_in;

   always_comb begin
      try_limit_in  = try_limit_ff;
      timeout_in    = timeout_ff;
      def_expiry_in = def_expiry_ff;
      fix_expiry_in = fix_expiry_ff;
      fix_load_in   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRY_LIMIT:        try_limit_in  = csr_wdata[3:0];
            CSR_RESPONSE_TIMEOUT: timeout_in    = csr_wdata;
            CSR_DEFAULT_EXPIRY:   def_expiry_in = csr_wdata;
            CSR_FIXED_EXPIRY: begin
               fix_expiry_in = csr_wdata;
               fix_load_in   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         try_limit_ff  <= TRY_LIMIT_RST;
         timeout_ff    <= RESPONSE_TIMEOUT_RST;
         def_expiry_ff <= DEFAULT_EXPIRY_RST;
         fix_expiry_ff <= FIXED_EXPIRY_RST;
         fix_load_ff   <= 1'b0;
      end else begin
         try_limit_ff  <= try_limit_in;
         timeout_ff    <= timeout_in;
         def_expiry_ff <= def_expiry_in;
         fix_expiry_ff <= fix_expiry_in;
         fix_load_ff   <= fix_load_in;
      end
   end

   assign cfg.try_limit           = try_limit_ff;
   assign cfg.response_timeout_ms = timeout_ff;
   assign cfg.default_expiry_s    = def_expiry_ff;
   assign cfg.fixed_expiry_s      = fix_expiry_ff;
   assign cfg.fixed_load          = fix_load_ff;

endmodule

`default_nettype wire

@@ rtl/srcu_engine.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller engine
// Registration state and the single-pass update applied to each request.
// ----------------------------------------------------------------------------
`default_nettype none

module srcu_engine
   import srcu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  step,
   input  req_item_type item,
   input  csr_cfg_type  cfg,
   output rsp_item_type result
);

   phase_type   phase_ff,   phase_in;
   logic [3:0]  tries_ff,   tries_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [26:0] rerem_ff,   rerem_in;
   logic [15:0] held_ff,    held_in;
   logic        flag_ff,    flag_in;
   logic [15:0] errors_ff,  errors_in;
   logic [15:0] succ_ff,    succ_in;

   logic [15:0] elapsed_inc;
   logic [26:0] rerem_dec;
   logic        resp_expired;
   logic        exhausted;
   logic [3:0]  tries_spent;
   logic [15:0] errors_inc;
   logic [15:0] succ_inc;
   logic [15:0] held_new;
   logic [26:0] rerem_load;

   assign elapsed_inc  = (elapsed_ff != COUNT_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign rerem_dec    = (rerem_ff != '0) ? rerem_ff - 27'd1 : rerem_ff;
   assign resp_expired = (elapsed_inc >= cfg.response_timeout_ms);
   assign exhausted    = (tries_ff <= 4'd1);
   assign tries_spent  = exhausted ? 4'd0 : tries_ff - 4'd1;
   assign errors_inc   = (errors_ff != COUNT_MAX) ? errors_ff + 16'd1 : errors_ff;
   assign succ_inc     = (succ_ff != COUNT_MAX) ? succ_ff + 16'd1 : succ_ff;

   // Expiry learned from the first success unless already held.
   assign held_new = (held_ff != '0) ? held_ff :
                     (item.response_expiry_s != '0) ? item.response_expiry_s :
                     cfg.default_expiry_s;
   assign rerem_load = {11'd0, held_new} * {17'd0, MS_PER_S};

   always_comb begin
      phase_in   = phase_ff;
      tries_in   = tries_ff;
      elapsed_in = elapsed_ff;
      rerem_in   = rerem_ff;
      held_in    = held_ff;
      flag_in    = flag_ff;
      errors_in  = errors_ff;
      succ_in    = succ_ff;

      result = '0;
      result.error_kind = ERR_NONE;

      unique case (item.action)
         ACT_TICK: begin
            elapsed_in = elapsed_inc;
            rerem_in   = rerem_dec;
            unique case (phase_ff)
               PH_REGISTER: begin
                  result.send_register = 1'b1;
                  elapsed_in = '0;
                  phase_in   = PH_REGISTERING;
               end
               PH_UNREGISTER: begin
                  result.send_unregister = 1'b1;
                  elapsed_in = '0;
                  phase_in   = PH_UNREGISTERING;
               end
               PH_REGISTERING, PH_UNREGISTERING: begin
                  if (resp_expired) begin
                     errors_in = errors_inc;
                     if (exhausted) begin
                        tries_in = cfg.try_limit;
                        flag_in  = 1'b0;
                        phase_in = PH_UNREG;
                        result.error_kind = ERR_TIMEOUT;
                     end else begin
                        tries_in = tries_spent;
                        phase_in = (phase_ff == PH_REGISTERING) ? PH_REGISTER
                                                                : PH_UNREGISTER;
                     end
                  end
               end
               PH_REGISTERED: begin
                  if (rerem_dec == '0) begin
                     result.clear_auth = 1'b1;
                     tries_in = cfg.try_limit;
                     phase_in = PH_REGISTER;
                  end
               end
               default: ;
            endcase
         end
         ACT_RESPONSE: begin
            if (item.call_id_match) begin
               priority if (item.response_code == CODE_TRYING) begin
                  elapsed_in = '0;
               end else if (item.response_code == CODE_OK) begin
                  if (phase_ff == PH_REGISTERING) begin
                     held_in  = held_new;
                     rerem_in = rerem_load;
                     succ_in  = succ_inc;
                     flag_in  = 1'b1;
                     phase_in = PH_REGISTERED;
                     result.registered_event = 1'b1;
                  end else if (phase_ff == PH_UNREGISTERING) begin
                     flag_in  = 1'b0;
                     phase_in = PH_UNREG;
                     result.unregistered_event = 1'b1;
                  end
               end else if (item.response_code == CODE_UNAUTH ||
                            item.response_code == CODE_PROXY_AUTH) begin
                  if (exhausted) begin
                     tries_in = cfg.try_limit;
                     flag_in  = 1'b0;
                     phase_in = PH_UNREG;
                     result.error_kind = ERR_FORBIDDEN;
                  end else begin
                     tries_in = tries_spent;
                     result.load_auth = 1'b1;
                     if (phase_ff == PH_REGISTERING) begin
                        phase_in = PH_REGISTER;
                     end else if (phase_ff == PH_UNREGISTERING) begin
                        phase_in = PH_UNREGISTER;
                     end
                  end
               end else if (item.response_code == CODE_FORBIDDEN) begin
                  tries_in = cfg.try_limit;
                  flag_in  = 1'b0;
                  phase_in = PH_UNREG;
                  result.error_kind     = ERR_FORBIDDEN;
                  result.error_sip_code = item.response_code;
               end else if (item.response_code >= CODE_ERR_LOW &&
                            item.response_code <= CODE_ERR_HIGH) begin
                  errors_in = errors_inc;
                  tries_in  = cfg.try_limit;
                  flag_in   = 1'b0;
                  phase_in  = PH_UNREG;
                  result.error_kind     = ERR_REGISTER;
                  result.error_sip_code = item.response_code;
               end else begin
                  // Other codes leave the state alone.
               end
            end
         end
         ACT_REGISTER: begin
            tries_in = cfg.try_limit;
            phase_in = PH_REGISTER;
         end
         ACT_UNREGISTER: begin
            tries_in = cfg.try_limit;
            phase_in = PH_UNREGISTER;
         end
         default: ;
      endcase

      // A write of the fixed expiry register reloads the held expiry.
      if (cfg.fixed_load) begin
         held_in = cfg.fixed_expiry_s;
      end

      result.phase         = phase_in;
      result.is_registered = flag_in;
      result.error_count   = errors_in;
      result.success_count = succ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_UNREG;
         tries_ff   <= TRY_LIMIT_RST;
         elapsed_ff <= '0;
         rerem_ff   <= '0;
         held_ff    <= FIXED_EXPIRY_RST;
         flag_ff    <= 1'b0;
         errors_ff  <= '0;
         succ_ff    <= '0;
      end else begin
         if (step) begin
            phase_ff   <= phase_in;
            tries_ff   <= tries_in;
            elapsed_ff <= elapsed_in;
            rerem_ff   <= rerem_in;
            flag_ff    <= flag_in;
            errors_ff  <= errors_in;
            succ_ff    <= succ_in;
         end
         if (step || cfg.fixed_load) begin
            held_ff <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_sip_registration_controller_unit.sv @@
// ----------------------------------------------------------------------------
// SIP registration controller unit testbench
// Drives ticks, server responses and register or unregister requests through
// the request channel. A behavioral model of the registration state predicts
// every result, and each result is checked field by field as it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sip_registration_controller_unit;
   import srcu_pkg::*;

   // Clock, reset and the configuration port.
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   srcu_req_if req_if ();
   srcu_rsp_if rsp_if ();

   sip_registration_controller_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   // Configuration as the predictor sees it.
   logic [3:0]  cfg_try_limit;
   logic [15:0] cfg_timeout_ms;
   logic [15:0] cfg_default_expiry_s;

   // Predicted registration state. The re-registration timer is 27 bits wide
   // because the largest expiry of 65535 s is kept in milliseconds.
   phase_type   phase_now;
   logic [3:0]  tries_remaining;
   logic [15:0] resp_wait_ms;
   logic [26:0] rereg_left_ms;
   logic [15:0] expiry_hold_s;
   logic        reg_flag;
   logic [15:0] err_tally;
   logic [15:0] ok_tally;

   // Results predicted for accepted requests, oldest first.
   rsp_item_type pending_results[$];
   int unsigned  failures = 0;

   // Sender and receiver pacing.
   bit          sender_gaps_on = 1'b1;
   bit          rsp_stalls_on  = 1'b1;
   int unsigned burst_left     = 0;
   int unsigned stall_mode     = 0;
   int unsigned stall_left     = 0;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   function automatic void reset_prediction();
      cfg_try_limit        = TRY_LIMIT_RST;
      cfg_timeout_ms       = RESPONSE_TIMEOUT_RST;
      cfg_default_expiry_s = DEFAULT_EXPIRY_RST;
      expiry_hold_s        = FIXED_EXPIRY_RST;
      phase_now            = PH_UNREG;
      tries_remaining      = TRY_LIMIT_RST;
      resp_wait_ms         = '0;
      rereg_left_ms        = '0;
      reg_flag             = 1'b0;
      err_tally            = '0;
      ok_tally             = '0;
   endfunction

   function automatic logic [15:0] sat_bump(input logic [15:0] count);
      return (count == COUNT_MAX) ? count : count + 16'd1;
   endfunction

   // Spends one send attempt. Returns 1 when the budget is used up; a budget
   // of one or zero counts as exhausted and never wraps.
   function automatic bit burn_try();
      if (tries_remaining <= 4'd1) begin
         tries_remaining = '0;
         return 1'b1;
      end
      tries_remaining = tries_remaining - 4'd1;
      return 1'b0;
   endfunction

   function automatic void close_registration();
      tries_remaining = cfg_try_limit;
      reg_flag        = 1'b0;
      phase_now       = PH_UNREG;
   endfunction

   // Applies one request to the predicted state and returns the result that
   // the unit must produce for it.
   function automatic rsp_item_type next_registration_result(input req_item_type it);
      rsp_item_type r;
      logic         timer_expired;
      r = '0;
      case (it.action)
         ACT_TICK: begin
            if (resp_wait_ms != COUNT_MAX) resp_wait_ms = resp_wait_ms + 16'd1;
            if (rereg_left_ms != '0) rereg_left_ms = rereg_left_ms - 27'd1;
            timer_expired = (resp_wait_ms >= cfg_timeout_ms);
            case (phase_now)
               PH_REGISTER: begin
                  r.send_register = 1'b1;
                  resp_wait_ms    = '0;
                  phase_now       = PH_REGISTERING;
               end
               PH_UNREGISTER: begin
                  r.send_unregister = 1'b1;
                  resp_wait_ms      = '0;
                  phase_now         = PH_UNREGISTERING;
               end
               PH_REGISTERING, PH_UNREGISTERING: begin
                  if (timer_expired) begin
                     err_tally = sat_bump(err_tally);
                     if (burn_try()) begin
                        close_registration();
                        r.error_kind = ERR_TIMEOUT;
                     end else if (phase_now == PH_REGISTERING) begin
                        phase_now = PH_REGISTER;
                     end else begin
                        phase_now = PH_UNREGISTER;
                     end
                  end
               end
               PH_REGISTERED: begin
                  if (rereg_left_ms == '0) begin
                     r.clear_auth    = 1'b1;
                     tries_remaining = cfg_try_limit;
                     phase_now       = PH_REGISTER;
                  end
               end
               default: ;
            endcase
         end
         ACT_RESPONSE: begin
            if (it.call_id_match) begin
               if (it.response_code == CODE_TRYING) begin
                  resp_wait_ms = '0;
               end else if (it.response_code == CODE_OK) begin
                  if (phase_now == PH_REGISTERING) begin
                     if (expiry_hold_s == '0) begin
                        expiry_hold_s = (it.response_expiry_s != '0) ?
                                        it.response_expiry_s : cfg_default_expiry_s;
                     end
                     rereg_left_ms      = 27'(expiry_hold_s) * 27'(MS_PER_S);
                     ok_tally           = sat_bump(ok_tally);
                     reg_flag           = 1'b1;
                     phase_now          = PH_REGISTERED;
                     r.registered_event = 1'b1;
                  end else if (phase_now == PH_UNREGISTERING) begin
                     reg_flag             = 1'b0;
                     phase_now            = PH_UNREG;
                     r.unregistered_event = 1'b1;
                  end
               end else if (it.response_code == CODE_UNAUTH ||
                            it.response_code == CODE_PROXY_AUTH) begin
                  if (burn_try()) begin
                     close_registration();
                     r.error_kind = ERR_FORBIDDEN;
                  end else begin
                     r.load_auth = 1'b1;
                     if (phase_now == PH_REGISTERING) phase_now = PH_REGISTER;
                     else if (phase_now == PH_UNREGISTERING) phase_now = PH_UNREGISTER;
                  end
               end else if (it.response_code == CODE_FORBIDDEN) begin
                  close_registration();
                  r.error_kind     = ERR_FORBIDDEN;
                  r.error_sip_code = it.response_code;
               end else if (it.response_code >= CODE_ERR_LOW &&
                            it.response_code <= CODE_ERR_HIGH) begin
                  err_tally = sat_bump(err_tally);
                  close_registration();
                  r.error_kind     = ERR_REGISTER;
                  r.error_sip_code = it.response_code;
               end
            end
         end
         ACT_REGISTER: begin
            tries_remaining = cfg_try_limit;
            phase_now       = PH_REGISTER;
         end
         default: begin
            tries_remaining = cfg_try_limit;
            phase_now       = PH_UNREGISTER;
         end
      endcase
      r.phase         = phase_now;
      r.is_registered = reg_flag;
      r.error_count   = err_tally;
      r.success_count = ok_tally;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Outputs are sampled at the rising edge, so the values seen here are the
   // ones the unit presented before the edge.
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            failures++;
            $error("result arrived with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("send_register", want.send_register, rsp_if.send_register);
            check_field("send_unregister", want.send_unregister, rsp_if.send_unregister);
            check_field("load_auth", want.load_auth, rsp_if.load_auth);
            check_field("clear_auth", want.clear_auth, rsp_if.clear_auth);
            check_field("error_kind", want.error_kind, rsp_if.error_kind);
            check_field("error_sip_code", want.error_sip_code, rsp_if.error_sip_code);
            check_field("registered_event", want.registered_event,
                        rsp_if.registered_event);
            check_field("unregistered_event", want.unregistered_event,
                        rsp_if.unregistered_event);
            check_field("phase", want.phase, rsp_if.phase);
            check_field("is_registered", want.is_registered, rsp_if.is_registered);
            check_field("error_count", want.error_count, rsp_if.error_count);
            check_field("success_count", want.success_count, rsp_if.success_count);
         end
      end
   end

   // The receiver switches between stall patterns every so often: always
   // ready, random back-pressure, a short periodic ready pattern, and long
   // on/off stretches.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 128);
      end else begin
         stall_left--;
      end
      if (!rsp_stalls_on) begin
         rsp_if.ready <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_if.ready <= (stall_left % 3 == 0);
            default: rsp_if.ready <= ((stall_left / 8) % 2 == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request driving
   // -------------------------------------------------------------------------

   function automatic req_item_type make_request(input action_type act, input logic match,
                                                 input logic [9:0] code,
                                                 input logic [15:0] expiry_s);
      req_item_type it;
      it.action            = act;
      it.call_id_match     = match;
      it.response_code     = code;
      it.response_expiry_s = expiry_s;
      return it;
   endfunction

   // Sends one request and records its predicted result once it is accepted.
   // Requests go out in bursts of random length; between bursts valid drops
   // for a random number of cycles. Inputs change only at the falling edge.
   task automatic send_request(input req_item_type it);
      int unsigned pause;
      if (sender_gaps_on && burst_left == 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         pause = $urandom_range(0, 5);
         repeat (pause) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) burst_left--;
      @(negedge clock);
      req_if.valid             <= 1'b1;
      req_if.action            <= it.action;
      req_if.call_id_match     <= it.call_id_match;
      req_if.response_code     <= it.response_code;
      req_if.response_expiry_s <= it.response_expiry_s;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      pending_results.push_back(next_registration_result(it));
   endtask

   // Stops sending and waits until every predicted result has been taken,
   // then lets the input and output registers run empty.
   task automatic settle_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register. The unit must be idle when this is called.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_TRY_LIMIT:        cfg_try_limit = value[3:0];
         CSR_RESPONSE_TIMEOUT: cfg_timeout_ms = value;
         CSR_DEFAULT_EXPIRY:   cfg_default_expiry_s = value;
         default:              expiry_hold_s = value;
      endcase
   endtask

   task automatic apply_config(input logic [3:0] try_limit, input logic [15:0] timeout_ms,
                               input logic [15:0] default_s, input logic [15:0] fixed_s);
      settle_pipeline();
      write_csr(CSR_TRY_LIMIT, 16'(try_limit));
      write_csr(CSR_RESPONSE_TIMEOUT, timeout_ms);
      write_csr(CSR_DEFAULT_EXPIRY, default_s);
      write_csr(CSR_FIXED_EXPIRY, fixed_s);
   endtask

   // -------------------------------------------------------------------------
   // Random request shaping
   // -------------------------------------------------------------------------

   // Status codes weighted toward the ones the unit acts on, with edges of the
   // error range and codes that must be ignored mixed in.
   function automatic logic [9:0] pick_status_code();
      case ($urandom_range(0, 9))
         0, 1: return CODE_OK;
         2:    return CODE_TRYING;
         3:    return CODE_UNAUTH;
         4:    return CODE_PROXY_AUTH;
         5:    return CODE_FORBIDDEN;
         6:    return 10'($urandom_range(400, 600));
         7:    return 10'($urandom_range(0, 399));
         8:    return 10'($urandom_range(601, 999));
         default: begin
            case ($urandom_range(0, 5))
               0:       return 10'd399;
               1:       return CODE_ERR_LOW;
               2:       return CODE_ERR_HIGH;
               3:       return 10'd601;
               4:       return 10'd0;
               default: return 10'd999;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_expiry();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 16'($urandom_range(1, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // Most requests follow a plausible registration flow for the predicted
   // phase, so the stream keeps reaching the deeper phases; about one in ten
   // is pure noise, including responses from foreign dialogs.
   function automatic req_item_type shaped_request();
      req_item_type it;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      it   = make_request(ACT_TICK, 1'b1, pick_status_code(), pick_expiry());
      if (pick < 10) begin
         it.action        = action_type'($urandom_range(0, 3));
         it.call_id_match = 1'($urandom_range(0, 1));
         return it;
      end
      case (phase_now)
         PH_UNREG: begin
            if (pick < 60) it.action = ACT_REGISTER;
            else if (pick < 70) it.action = ACT_UNREGISTER;
            else if (pick < 85) it.action = ACT_TICK;
            else it.action = ACT_RESPONSE;
         end
         PH_REGISTER, PH_UNREGISTER: begin
            if (pick < 85) it.action = ACT_TICK;
            else if (pick < 95) it.action = ACT_RESPONSE;
            else if (pick < 98) it.action = ACT_REGISTER;
            else it.action = ACT_UNREGISTER;
         end
         PH_REGISTERING, PH_UNREGISTERING: begin
            if (pick < 45) it.action = ACT_TICK;
            else if (pick < 90) it.action = ACT_RESPONSE;
            else if (pick < 95) it.action = ACT_REGISTER;
            else it.action = ACT_UNREGISTER;
         end
         PH_REGISTERED: begin
            if (pick < 60) it.action = ACT_TICK;
            else if (pick < 75) it.action = ACT_RESPONSE;
            else if (pick < 90) it.action = ACT_UNREGISTER;
            else it.action = ACT_REGISTER;
         end
         default: it.action = ACT_TICK;
      endcase
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // A full register and unregister cycle on the reset configuration. The
   // first success learns the expiry from the default, since the response
   // carries none. Foreign responses, a success outside the sending phases,
   // an ignored code and an authorization challenge while registered are
   // mixed in.
   task automatic test_register_cycle();
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_TRYING, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b0, CODE_OK, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'hFFFF));
      send_request(make_request(ACT_RESPONSE, 1'b1, 10'd302, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_UNAUTH, 16'd0));
      send_request(make_request(ACT_UNREGISTER, 1'b1, 10'h3FF, 16'hFFFF));
      send_request(make_request(ACT_TICK, 1'b1, 10'h3FF, 16'hFFFF));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_PROXY_AUTH, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));
   endtask

   // Forbidden access, the edges of the register-error range and codes just
   // outside it, which must change nothing.
   task automatic test_error_responses();
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b0, CODE_FORBIDDEN, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_FORBIDDEN, 16'd0));
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_ERR_LOW, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_ERR_HIGH, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, 10'd601, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, 10'd399, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, 10'd999, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, 10'd0, 16'd0));
   endtask

   // Response timeouts, a provisional response restarting the timer, and the
   // retry budget running out both by timeout and by repeated challenges.
   task automatic test_retry_budget();
      apply_config(4'd2, 16'd2, DEFAULT_EXPIRY_RST, 16'd0);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_TRYING, 16'd0));
      repeat (2) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      repeat (3) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_UNREGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_PROXY_AUTH, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_UNAUTH, 16'd0));

      // A budget of one attempt gives up on the first challenge.
      settle_pipeline();
      write_csr(CSR_TRY_LIMIT, 16'd1);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_UNAUTH, 16'd0));

      // The largest budget and the longest timeout never expire here.
      settle_pipeline();
      write_csr(CSR_TRY_LIMIT, 16'd15);
      write_csr(CSR_RESPONSE_TIMEOUT, 16'hFFFF);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      repeat (3) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));
   endtask

   // Re-registration after the held expiry runs out, expiry learned from the
   // response or from the default, and the largest expiry on both sources.
   task automatic test_reregistration();
      apply_config(4'd3, 16'hFFFF, DEFAULT_EXPIRY_RST, 16'd1);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd7));
      repeat (1001) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));

      // Zero preset: the expiry is learned from the response.
      settle_pipeline();
      write_csr(CSR_FIXED_EXPIRY, 16'd0);
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd2));
      repeat (3) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));

      // Zero preset and no expiry in the response: the default applies.
      settle_pipeline();
      write_csr(CSR_DEFAULT_EXPIRY, 16'd1);
      write_csr(CSR_FIXED_EXPIRY, 16'd0);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));
      repeat (3) send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));

      settle_pipeline();
      write_csr(CSR_FIXED_EXPIRY, 16'hFFFF);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));

      settle_pipeline();
      write_csr(CSR_DEFAULT_EXPIRY, 16'hFFFF);
      write_csr(CSR_FIXED_EXPIRY, 16'd0);
      send_request(make_request(ACT_REGISTER, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_TICK, 1'b0, 10'd0, 16'd0));
      send_request(make_request(ACT_RESPONSE, 1'b1, CODE_OK, 16'd0));
   endtask

   // Shaped random traffic under three settings: the smallest values, the
   // largest budget and default expiry with learning enabled, and a random
   // mix. Short response timeouts let the retry paths fire often.
   task automatic test_random_traffic();
      for (int batch = 0; batch < 3; batch++) begin
         case (batch)
            0: apply_config(4'd1, 16'd1, 16'd1, 16'd1);
            1: apply_config(4'd15, 16'd9, 16'hFFFF, 16'd0);
            default: apply_config(4'($urandom_range(2, 14)), 16'($urandom_range(2, 16)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(0, 2)));
         endcase
         for (int n = 0; n < 150; n++) begin
            // Once in the run the sender holds off until every result is in.
            if (batch == 1 && n == 75) settle_pipeline();
            send_request(shaped_request());
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Run
   // -------------------------------------------------------------------------

   initial begin
      reset                    = 1'b1;
      csr_write_en             = 1'b0;
      csr_index                = CSR_TRY_LIMIT;
      csr_wdata                = '0;
      req_if.valid             = 1'b0;
      req_if.action            = ACT_TICK;
      req_if.call_id_match     = 1'b0;
      req_if.response_code     = '0;
      req_if.response_expiry_s = '0;
      rsp_if.ready             = 1'b1;
      reset_prediction();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_cycle();
      test_error_responses();
      test_retry_budget();
      test_reregistration();
      test_random_traffic();

      settle_pipeline();
      if (failures == 0) begin
         $display("sip_registration_controller_unit verification clean");
      end else begin
         $display("sip_registration_controller_unit verification failed");
      end
      $finish;
   end

   // This bound stops a run that hangs; a correct run ends well within it.
   initial begin
      #6000000;
      $display("sip_registration_controller_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ sip_registration_controller_unit.f @@
rtl/srcu_pkg.sv
rtl/srcu_if.sv
rtl/srcu_csr.sv
rtl/srcu_engine.sv
rtl/sip_registration_controller_unit.sv
verif/tb_sip_registration_controller_unit.sv
